### rtl/core/hsvg_pkg.sv
// ============================================================================
// hsvg_pkg : shared types and constants for the HSV to GRB pixel converter
// Sector coding, stage numbering and the fixed arithmetic constants.
// ============================================================================
package hsvg_pkg;

    localparam int IDX_W  = 3;
    localparam int CHAN_W = 8;

    // Pipeline stage numbering
    localparam int ST_SECTOR  = 0;
    localparam int ST_PRODUCT = 1;
    localparam int ST_MIX     = 2;
    localparam int ST_GAMMA0  = 3;
    localparam int GAMMA_DEPTH = 4;
    localparam int PIPE_DEPTH  = ST_GAMMA0 + GAMMA_DEPTH;

    localparam logic [CHAN_W-1:0] HUE_SECTOR   = 8'd43;
    localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;
    localparam logic [CHAN_W-1:0] GAMMA_GAIN   = 8'd251;
    localparam logic [CHAN_W-1:0] GAMMA_OFFSET = 8'd4;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    typedef logic [PIPE_DEPTH-1:0] t_stage_en;

    // First hue value of each sector
    function automatic logic [CHAN_W-1:0] sector_base(input t_sector sec);
        logic [CHAN_W-1:0] base;
        case (sec)
            SEC_RED:     base = '0;
            SEC_YELLOW:  base = HUE_SECTOR;
            SEC_GREEN:   base = CHAN_W'(2 * HUE_SECTOR);
            SEC_CYAN:    base = CHAN_W'(3 * HUE_SECTOR);
            SEC_BLUE:    base = CHAN_W'(4 * HUE_SECTOR);
            SEC_MAGENTA: base = CHAN_W'(5 * HUE_SECTOR);
            default:     base = '0;
        endcase
        return base;
    endfunction

    // hue / 43 by threshold compare
    function automatic t_sector hue_sector(input logic [CHAN_W-1:0] hue);
        t_sector sec;
        if (hue >= sector_base(SEC_MAGENTA)) begin
            sec = SEC_MAGENTA;
        end else if (hue >= sector_base(SEC_BLUE)) begin
            sec = SEC_BLUE;
        end else if (hue >= sector_base(SEC_CYAN)) begin
            sec = SEC_CYAN;
        end else if (hue >= sector_base(SEC_GREEN)) begin
            sec = SEC_GREEN;
        end else if (hue >= sector_base(SEC_YELLOW)) begin
            sec = SEC_YELLOW;
        end else begin
            sec = SEC_RED;
        end
        return sec;
    endfunction

endpackage

### rtl/core/hsvg_sector.sv
// ============================================================================
// hsvg_sector : hue sector and scaled remainder stage
// Splits the hue into one of six sectors and the offset inside it times six.
// ============================================================================
module hsvg_sector (
    input  logic                                i_clk,
    input  hsvg_pkg::t_stage_en                 i_en,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_hue,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_saturation,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_brightness,
    output hsvg_pkg::t_sector                   o_sector,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_rem,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_saturation,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_brightness
);

    hsvg_pkg::t_sector                  n_sector;
    logic [hsvg_pkg::CHAN_W-1:0]        n_diff;
    logic [hsvg_pkg::CHAN_W-1:0]        n_rem;

    hsvg_pkg::t_sector                  r_sector;
    logic [hsvg_pkg::CHAN_W-1:0]        r_rem;
    logic [hsvg_pkg::CHAN_W-1:0]        r_saturation;
    logic [hsvg_pkg::CHAN_W-1:0]        r_brightness;

    always_comb begin
        n_sector = hsvg_pkg::hue_sector(i_hue);
        n_diff   = i_hue - hsvg_pkg::sector_base(n_sector);
        // offset stays below 43, so six times it fits a byte: 4x + 2x
        n_rem    = {n_diff[5:0], 2'b00} + {1'b0, n_diff[5:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[hsvg_pkg::ST_SECTOR]) begin
            r_sector     <= n_sector;
            r_rem        <= n_rem;
            r_saturation <= i_saturation;
            r_brightness <= i_brightness;
        end
    end

    assign o_sector     = r_sector;
    assign o_rem        = r_rem;
    assign o_saturation = r_saturation;
    assign o_brightness = r_brightness;

endmodule

### rtl/core/hsvg_mix.sv
// ============================================================================
// hsvg_mix : p, q and t products and channel selection
// Two stages: first-level products, then q and t and the per-sector mux.
// ============================================================================
module hsvg_mix (
    input  logic                                i_clk,
    input  hsvg_pkg::t_stage_en                 i_en,
    input  hsvg_pkg::t_sector                   i_sector,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_rem,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_saturation,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_brightness,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_red,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_green,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_blue
);

    localparam int PW = 2 * hsvg_pkg::CHAN_W;

    logic [PW-1:0]                  n_p_prod;
    logic [PW-1:0]                  n_sq_prod;
    logic [PW-1:0]                  n_st_prod;
    logic [PW-1:0]                  n_q_prod;
    logic [PW-1:0]                  n_t_prod;
    logic [hsvg_pkg::CHAN_W-1:0]    n_q;
    logic [hsvg_pkg::CHAN_W-1:0]    n_t;
    logic [hsvg_pkg::CHAN_W-1:0]    n_red;
    logic [hsvg_pkg::CHAN_W-1:0]    n_green;
    logic [hsvg_pkg::CHAN_W-1:0]    n_blue;

    logic [hsvg_pkg::CHAN_W-1:0]    r_p;
    logic [hsvg_pkg::CHAN_W-1:0]    r_sq;
    logic [hsvg_pkg::CHAN_W-1:0]    r_st;
    logic [hsvg_pkg::CHAN_W-1:0]    r_bri;
    hsvg_pkg::t_sector              r_sector;
    logic                           r_grey;
    logic [hsvg_pkg::CHAN_W-1:0]    r_red;
    logic [hsvg_pkg::CHAN_W-1:0]    r_green;
    logic [hsvg_pkg::CHAN_W-1:0]    r_blue;

    // products of the first level
    always_comb begin
        n_p_prod  = PW'(i_brightness) * PW'(hsvg_pkg::CHAN_MAX - i_saturation);
        n_sq_prod = PW'(i_saturation) * PW'(i_rem);
        n_st_prod = PW'(i_saturation) * PW'(hsvg_pkg::CHAN_MAX - i_rem);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[hsvg_pkg::ST_PRODUCT]) begin
            r_p      <= n_p_prod[PW-1:hsvg_pkg::CHAN_W];
            r_sq     <= n_sq_prod[PW-1:hsvg_pkg::CHAN_W];
            r_st     <= n_st_prod[PW-1:hsvg_pkg::CHAN_W];
            r_bri    <= i_brightness;
            r_sector <= i_sector;
            r_grey   <= (i_saturation == '0);
        end
    end

    // q and t, then route to channels
    always_comb begin
        n_q_prod = PW'(r_bri) * PW'(hsvg_pkg::CHAN_MAX - r_sq);
        n_t_prod = PW'(r_bri) * PW'(hsvg_pkg::CHAN_MAX - r_st);
        n_q      = n_q_prod[PW-1:hsvg_pkg::CHAN_W];
        n_t      = n_t_prod[PW-1:hsvg_pkg::CHAN_W];
        case (r_sector)
            hsvg_pkg::SEC_RED: begin
                n_red = r_bri; n_green = n_t; n_blue = r_p;
            end
            hsvg_pkg::SEC_YELLOW: begin
                n_red = n_q; n_green = r_bri; n_blue = r_p;
            end
            hsvg_pkg::SEC_GREEN: begin
                n_red = r_p; n_green = r_bri; n_blue = n_t;
            end
            hsvg_pkg::SEC_CYAN: begin
                n_red = r_p; n_green = n_q; n_blue = r_bri;
            end
            hsvg_pkg::SEC_BLUE: begin
                n_red = n_t; n_green = r_p; n_blue = r_bri;
            end
            default: begin
                n_red = r_bri; n_green = r_p; n_blue = n_q;
            end
        endcase
        if (r_grey) begin
            n_red   = r_bri;
            n_green = r_bri;
            n_blue  = r_bri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[hsvg_pkg::ST_MIX]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

### rtl/core/hsvg_gamma.sv
// ============================================================================
// hsvg_gamma : gamma correction of one channel
// Cube, scale by 251, keep the top byte and add the offset; zero stays zero.
// ============================================================================
module hsvg_gamma (
    input  logic                                i_clk,
    input  hsvg_pkg::t_stage_en                 i_en,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_chan,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_chan
);

    localparam int CW  = hsvg_pkg::CHAN_W;
    localparam int SW  = 2 * CW;
    localparam int KW  = 3 * CW;
    localparam int YW  = 4 * CW;

    logic [YW-1:0]  n_y;

    logic [CW-1:0]  r_c;
    logic [SW-1:0]  r_c2;
    logic           r_nz_a;
    logic [KW-1:0]  r_c3;
    logic           r_nz_b;
    logic [CW-1:0]  r_y;
    logic           r_nz_c;
    logic [CW-1:0]  r_out;

    assign n_y = YW'(r_c3) * YW'(hsvg_pkg::GAMMA_GAIN);

    always_ff @(posedge i_clk) begin
        if (i_en[hsvg_pkg::ST_GAMMA0]) begin
            r_c    <= i_chan;
            r_c2   <= SW'(i_chan) * SW'(i_chan);
            r_nz_a <= (i_chan != '0);
        end
        if (i_en[hsvg_pkg::ST_GAMMA0 + 1]) begin
            r_c3   <= KW'(r_c2) * KW'(r_c);
            r_nz_b <= r_nz_a;
        end
        if (i_en[hsvg_pkg::ST_GAMMA0 + 2]) begin
            r_y    <= n_y[YW-1:YW-CW];
            r_nz_c <= r_nz_b;
        end
        if (i_en[hsvg_pkg::ST_GAMMA0 + 3]) begin
            r_out  <= r_nz_c ? (r_y + hsvg_pkg::GAMMA_OFFSET) : '0;
        end
    end

    assign o_chan = r_out;

endmodule

### rtl/core/hsv_to_grb_led_pixel.sv
// ============================================================================
// hsv_to_grb_led_pixel : HSV colour to gamma-corrected GRB LED pixel
// Seven-stage pipeline from hue/saturation/brightness to LED byte order.
// ============================================================================
// Usage
//   Input channel: present led_index, hue, saturation and brightness with
//   i_valid; a transfer takes place at a clock edge with i_valid high and
//   o_stall low. Output channel: o_valid with the LED index and the green,
//   red and blue bytes; a transfer takes place when o_valid is high and
//   i_stall is low.
//   An input transfer passes the sector, product, mix and gamma stage
//   registers in turn to o_valid. Throughput is one pixel per cycle when
//   i_stall is low; the seven registered stages hold one item each.
//   Each stage advances when it is empty or its successor advances, so
//   bubbles collapse and a stalled receiver only backs up the pipeline
//   once every stage holds an item; then o_stall rises and the output
//   payload holds until taken.
//   Reset (synchronous, active low) drops every item in flight; payload
//   registers are not cleared. The LED index is passed through untouched,
//   also when it lies beyond the string.
// ============================================================================
module hsv_to_grb_led_pixel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [hsvg_pkg::IDX_W-1:0]          i_led_index,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_hue,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_saturation,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_brightness,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [hsvg_pkg::IDX_W-1:0]          o_pixel_index,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_green_out,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_red_out,
    output logic [hsvg_pkg::CHAN_W-1:0]         o_blue_out
);

    localparam int DEPTH = hsvg_pkg::PIPE_DEPTH;

    // stage valid bits and per-stage advance
    logic [DEPTH-1:0]               r_vld;
    logic [DEPTH-1:0]               n_vld;
    hsvg_pkg::t_stage_en            rdy;

    // LED index delay line, one tap per stage
    logic [hsvg_pkg::IDX_W-1:0]     r_idx [DEPTH];

    // datapath between parts
    hsvg_pkg::t_sector              s0_sector;
    logic [hsvg_pkg::CHAN_W-1:0]    s0_rem;
    logic [hsvg_pkg::CHAN_W-1:0]    s0_sat;
    logic [hsvg_pkg::CHAN_W-1:0]    s0_bri;
    logic [hsvg_pkg::CHAN_W-1:0]    mix_red;
    logic [hsvg_pkg::CHAN_W-1:0]    mix_green;
    logic [hsvg_pkg::CHAN_W-1:0]    mix_blue;

    // A stage may load when it is empty or the one after it moves on.
    always_comb begin
        rdy[DEPTH-1] = !r_vld[DEPTH-1] || !i_stall;
        for (int k = DEPTH - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign n_vld = {r_vld[DEPTH-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Index travels alongside the colour; no reset needed on payload.
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_idx[0] <= i_led_index;
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (rdy[k]) begin
                r_idx[k] <= r_idx[k-1];
            end
        end
    end

    hsvg_sector u_sector (
        .i_clk        (i_clk),
        .i_en         (rdy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_sector     (s0_sector),
        .o_rem        (s0_rem),
        .o_saturation (s0_sat),
        .o_brightness (s0_bri)
    );

    hsvg_mix u_mix (
        .i_clk        (i_clk),
        .i_en         (rdy),
        .i_sector     (s0_sector),
        .i_rem        (s0_rem),
        .i_saturation (s0_sat),
        .i_brightness (s0_bri),
        .o_red        (mix_red),
        .o_green      (mix_green),
        .o_blue       (mix_blue)
    );

    hsvg_gamma u_gamma_green (
        .i_clk  (i_clk),
        .i_en   (rdy),
        .i_chan (mix_green),
        .o_chan (o_green_out)
    );

    hsvg_gamma u_gamma_red (
        .i_clk  (i_clk),
        .i_en   (rdy),
        .i_chan (mix_red),
        .o_chan (o_red_out)
    );

    hsvg_gamma u_gamma_blue (
        .i_clk  (i_clk),
        .i_en   (rdy),
        .i_chan (mix_blue),
        .o_chan (o_blue_out)
    );

    // Back-pressure only when the first stage cannot load.
    assign o_stall       = !rdy[0];
    assign o_valid       = r_vld[DEPTH-1];
    assign o_pixel_index = r_idx[DEPTH-1];

endmodule

### rtl/core/hsvg_checker.sv
// ============================================================================
// hsvg_checker : port-level checks for the HSV to GRB pixel converter
// Tracks items in flight and checks occupancy, back-pressure and reset.
// ============================================================================
module hsvg_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [hsvg_pkg::IDX_W-1:0]          i_pixel_index,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_green,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_red,
    input  logic [hsvg_pkg::CHAN_W-1:0]         i_blue
);

    localparam int CNT_W = $clog2(hsvg_pkg::PIPE_DEPTH + 1);

    logic               in_xfer;
    logic               out_xfer;
    logic [CNT_W-1:0]   r_cnt;

    assign in_xfer  = i_in_valid && !i_in_stall;
    assign out_xfer = i_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_pixel_index)
            && $stable(i_green) && $stable(i_red) && $stable(i_blue))
        else $error("stalled result changed");

    // input back-pressure only when a result is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid && i_out_stall)
        else $error("input stalled without blocked output");

    // never more items in flight than stages
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(hsvg_pkg::PIPE_DEPTH))
        else $error("too many items in flight");

    // no result without an item in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !i_out_valid)
        else $error("result with nothing in flight");

    // reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

endmodule

bind hsv_to_grb_led_pixel hsvg_checker u_hsvg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_valid),
    .i_in_stall    (o_stall),
    .i_out_valid   (o_valid),
    .i_out_stall   (i_stall),
    .i_pixel_index (o_pixel_index),
    .i_green       (o_green_out),
    .i_red         (o_red_out),
    .i_blue        (o_blue_out)
);
